// ===== rtl/ffa_pkg.sv =====
// Shared widths, header layout and register reset value for the first-fit allocator.
// No dependencies; imported by the top level and the checker.
`timescale 1ns / 1ps

package ffa_pkg;

	localparam int REQ_W      = 16;
	localparam int CFG_W      = 17;
	localparam int OFS_W      = 16;
	localparam int FREE_W     = 17;
	localparam int SZ_W       = 17;
	localparam int HDR_W      = 32;
	localparam int USED_BIT   = 31;
	localparam int HDR_BYTES  = 4;
	localparam int HDR_SH     = 2;
	localparam int MIN_LEN    = 8;
	localparam int LEN_CAP    = 131068;

	localparam int S_TDATA_W  = 16;
	localparam int M_TDATA_W  = 40;
	localparam int M_TUSER_W  = 1;

	localparam logic [CFG_W-1:0] HEAP_SIZE_RST = 17'd65536;

	typedef logic [HDR_W-1:0] hdr_t;

endpackage

// ===== rtl/ffa_ram.sv =====
// Generic single-port-write, single-port-read synchronous RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module ffa_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/first_fit_heap_allocator_top.sv =====
// First-fit heap allocator: header walk over an implicit block list held in one RAM.
// Depends on ffa_pkg and ffa_ram.
`timescale 1ns / 1ps

// The heap is a chain of 4-byte headers (used bit 31, payload size below) kept in a
// synchronous RAM of HEAP_BYTES/4 words; only headers are ever written, so no clearing
// pass runs: after reset or a heap_size write the INIT state writes the first header.
// For each request the DIV and NEED states round the size to the alignment through a
// reciprocal multiply, then the walk in EVAL reads one header per cycle from the RAM
// port until one fits or the end of the heap is reached, MARK writes the used header
// when the chosen block is split, RESP loads the result register once the output is
// free, and IDLE takes the next request.
// A new request is taken once the previous result sits in the output register.
module first_fit_heap_allocator_top import ffa_pkg::*; #(
	parameter int HEAP_BYTES  = 65536,
	parameter int ALIGN_BYTES = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,   // [15:0] request_bytes
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_TDATA_W-1:0] m_tdata,   // [15:0] payload_offset, [32:16] free_bytes
	output logic [M_TUSER_W-1:0] m_tuser,   // [0] granted
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_W-1:0]     cfg_data   // heap_size
);

	localparam int WORDS = HEAP_BYTES / HDR_BYTES;
	localparam int AW    = $clog2(WORDS);
	localparam int XW    = REQ_W + 1;
	localparam int NW    = XW + 1;
	localparam int PW    = CFG_W + 1;
	localparam int TW    = PW + 1;
	localparam int RSH   = XW + $clog2(ALIGN_BYTES);
	localparam longint RECIP = ((64'd1 << RSH) + ALIGN_BYTES - 1) / ALIGN_BYTES;
	localparam int RW    = $clog2(RECIP + 1);
	localparam int PRW   = XW + RW;
	localparam logic [CFG_W-1:0] LEN_MAX =
		(HEAP_BYTES > LEN_CAP) ? CFG_W'(LEN_CAP) : CFG_W'(HEAP_BYTES);

	localparam logic [2:0] ST_INIT = 3'd0;
	localparam logic [2:0] ST_IDLE = 3'd1;
	localparam logic [2:0] ST_DIV  = 3'd2;
	localparam logic [2:0] ST_NEED = 3'd3;
	localparam logic [2:0] ST_EVAL = 3'd4;
	localparam logic [2:0] ST_MARK = 3'd5;
	localparam logic [2:0] ST_RESP = 3'd6;

	function automatic logic [CFG_W-1:0] len_of(input logic [CFG_W-1:0] v);
		logic [CFG_W-1:0] n;
		n = {v[CFG_W-1:HDR_SH], {HDR_SH{1'b0}}};
		if (n < CFG_W'(MIN_LEN)) begin
			n = CFG_W'(MIN_LEN);
		end else if (n > LEN_MAX) begin
			n = LEN_MAX;
		end
		return n;
	endfunction

	localparam logic [CFG_W-1:0] LEN_RST = len_of(HEAP_SIZE_RST);

	logic [2:0]        state_q;
	logic [CFG_W-1:0]  heap_len_q;
	logic [FREE_W-1:0] free_q;
	logic [XW-1:0]     x_q;
	logic [PRW-1:0]    prod_q;
	logic [NW-1:0]     need_q;
	logic [PW-1:0]     pos_q;
	logic              granted_q;
	logic [OFS_W-1:0]  offset_q;

	logic              m_tvalid_q;
	logic [M_TDATA_W-1:0] m_tdata_q;
	logic [M_TUSER_W-1:0] m_tuser_q;

	logic              ram_we;
	logic [AW-1:0]     ram_waddr;
	hdr_t              ram_wdata;
	logic [AW-1:0]     ram_raddr;
	hdr_t              ram_rdata;

	logic [XW-1:0]     quot;
	logic [NW-1:0]     need_a;
	logic [NW-1:0]     need_r;
	logic [NW-1:0]     need_w;
	logic [SZ_W-1:0]   h_size;
	logic              h_used;
	logic [TW-1:0]     size_e, need_e, pos_e, len_e, free_e;
	logic [TW-1:0]     rem, nxt, npos, dec_split;
	logic              fit, split, at_end;
	logic [FREE_W-1:0] free_split, free_whole;
	logic              cfg_wr, s_acc, resp_go;

	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid & cfg_ready;
	assign s_tready  = (state_q == ST_IDLE) & ~cfg_valid;
	assign s_acc     = s_tvalid & s_tready;
	assign resp_go   = (state_q == ST_RESP) & (~m_tvalid_q | m_tready);

	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = m_tdata_q;
	assign m_tuser   = m_tuser_q;

	always_comb begin
		quot   = XW'(prod_q >> RSH);
		need_a = NW'(NW'(quot) * NW'(ALIGN_BYTES));
		need_r = (NW'(x_q) - need_a >= NW'(ALIGN_BYTES)) ?
			need_a + NW'(ALIGN_BYTES) : need_a;
		need_w = (need_r + NW'(HDR_BYTES - 1)) & ~NW'(HDR_BYTES - 1);
	end

	always_comb begin
		h_used    = ram_rdata[USED_BIT];
		h_size    = ram_rdata[SZ_W-1:0];
		size_e    = TW'(h_size);
		need_e    = TW'(need_q);
		pos_e     = TW'(pos_q);
		len_e     = TW'(heap_len_q);
		free_e    = TW'(free_q);
		fit       = ~h_used & (size_e >= need_e);
		rem       = size_e - need_e;
		nxt       = pos_e + TW'(HDR_BYTES) + need_e;
		split     = (rem >= TW'(HDR_BYTES)) & (nxt + TW'(HDR_BYTES) <= len_e);
		npos      = pos_e + TW'(HDR_BYTES) + size_e;
		at_end    = npos + TW'(HDR_BYTES) > len_e;
		dec_split = need_e + TW'(HDR_BYTES);
		free_split = (free_e >= dec_split) ? FREE_W'(free_e - dec_split) : '0;
		free_whole = (free_e >= size_e) ? FREE_W'(free_e - size_e) : '0;
	end

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = AW'(pos_e >> HDR_SH);
		ram_wdata = '0;
		ram_raddr = (state_q == ST_EVAL) ? AW'(npos >> HDR_SH) : '0;
		case (state_q)
			ST_INIT: begin
				ram_we    = 1'b1;
				ram_waddr = '0;
				ram_wdata = HDR_W'(heap_len_q - CFG_W'(HDR_BYTES));
			end
			ST_EVAL: begin
				if (fit) begin
					ram_we = 1'b1;
					if (split) begin
						ram_waddr = AW'(nxt >> HDR_SH);
						ram_wdata = HDR_W'(rem - TW'(HDR_BYTES));
					end else begin
						ram_wdata = ram_rdata;
						ram_wdata[USED_BIT] = 1'b1;
					end
				end
			end
			ST_MARK: begin
				ram_we    = 1'b1;
				ram_wdata = HDR_W'(need_q);
				ram_wdata[USED_BIT] = 1'b1;
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	ffa_ram #(
		.WIDTH (HDR_W),
		.DEPTH (WORDS)
	) u_hdr_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_INIT;
			heap_len_q <= LEN_RST;
			free_q     <= FREE_W'(LEN_RST - CFG_W'(HDR_BYTES));
		end else if (cfg_wr) begin
			state_q    <= ST_INIT;
			heap_len_q <= len_of(cfg_data);
			free_q     <= FREE_W'(len_of(cfg_data) - CFG_W'(HDR_BYTES));
		end else begin
			case (state_q)
				ST_INIT: begin
					state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (s_acc) begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					state_q <= ST_NEED;
				end
				ST_NEED: begin
					state_q <= ST_EVAL;
				end
				ST_EVAL: begin
					if (fit) begin
						state_q <= split ? ST_MARK : ST_RESP;
						free_q  <= split ? free_split : free_whole;
					end else if (at_end) begin
						state_q <= ST_RESP;
					end
				end
				ST_MARK: begin
					state_q <= ST_RESP;
				end
				ST_RESP: begin
					if (resp_go) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Datapath registers: no reset needed
	always_ff @(posedge clk) begin
		if (s_acc) begin
			x_q <= XW'(s_tdata) + XW'(ALIGN_BYTES - 1);
		end
		if (state_q == ST_DIV) begin
			prod_q <= PRW'(x_q) * PRW'(RECIP);
		end
		if (state_q == ST_NEED) begin
			need_q <= need_w;
			pos_q  <= '0;
		end
		if (state_q == ST_EVAL) begin
			if (fit) begin
				granted_q <= 1'b1;
				offset_q  <= OFS_W'(pos_e + TW'(HDR_BYTES));
			end else if (at_end) begin
				granted_q <= 1'b0;
				offset_q  <= '0;
			end else begin
				pos_q <= PW'(npos);
			end
		end
		if (resp_go) begin
			m_tdata_q <= M_TDATA_W'({free_q, offset_q});
			m_tuser_q <= M_TUSER_W'(granted_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (resp_go) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

endmodule

// ===== rtl/ffa_checker.sv =====
// Port-level checks for the first-fit allocator, bound to the top level.
// Depends on ffa_pkg and first_fit_heap_allocator_top.
`timescale 1ns / 1ps

module ffa_checker import ffa_pkg::*; (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 s_tvalid,
	input logic                 s_tready,
	input logic                 m_tvalid,
	input logic                 m_tready,
	input logic [M_TDATA_W-1:0] m_tdata,
	input logic [M_TUSER_W-1:0] m_tuser,
	input logic                 cfg_valid,
	input logic                 cfg_ready
);

	logic              seen_q;
	logic              cfg_since_q;
	logic [FREE_W-1:0] last_free_q;
	logic              out_beat;

	assign out_beat = m_tvalid & m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q      <= 1'b0;
			cfg_since_q <= 1'b0;
			last_free_q <= '0;
		end else begin
			if (out_beat) begin
				seen_q      <= 1'b1;
				last_free_q <= m_tdata[OFS_W +: FREE_W];
			end
			if (cfg_valid && cfg_ready) begin
				cfg_since_q <= 1'b1;
			end else if (out_beat) begin
				cfg_since_q <= 1'b0;
			end
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result beat changed while stalled");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("request taken while another is in progress");

	a_refused_offset: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> m_tdata[OFS_W-1:0] == '0)
		else $error("refused request carries an offset");

	a_offset_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tdata[HDR_SH-1:0] == '0)
		else $error("granted offset not word aligned");

	a_free_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		out_beat && seen_q && !cfg_since_q |-> m_tdata[OFS_W +: FREE_W] <= last_free_q)
		else $error("free byte count grew without a heap reinitialisation");

endmodule

bind first_fit_heap_allocator_top ffa_checker u_ffa_checker (.*);
